// ----- hw/rtl/round_robin_thread_ring_scheduler_core_macros.svh -----
// assertion macros for the thread ring scheduler core
// used by the top level only, relies on clk and rst_n in scope
`ifndef ROUND_ROBIN_THREAD_RING_SCHEDULER_CORE_MACROS_SVH
`define ROUND_ROBIN_THREAD_RING_SCHEDULER_CORE_MACROS_SVH

// same-cycle implication
`define RRTS_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define RRTS_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ----- hw/rtl/rrts_pkg.sv -----
// shared types, codes and sizes of the thread ring scheduler
// no dependencies
`default_nettype none

package rrts_pkg;

  localparam int THREAD_SLOTS = 16;
  localparam int ID_W         = $clog2(THREAD_SLOTS);
  localparam int CNT_W        = $clog2(THREAD_SLOTS + 1);
  localparam int ROOT_W       = 52;
  localparam int OUT_ID_W     = 4;

  localparam logic [1:0] FN_CREATE_K = 2'd0;
  localparam logic [1:0] FN_CREATE_U = 2'd1;
  localparam logic [1:0] FN_YIELD    = 2'd2;
  localparam logic [1:0] FN_EXIT     = 2'd3;

  localparam logic [1:0] ST_DEAD    = 2'd0;
  localparam logic [1:0] ST_READY   = 2'd1;
  localparam logic [1:0] ST_RUNNING = 2'd2;
  localparam logic [1:0] ST_BLOCKED = 2'd3;

  typedef struct packed {
    logic [1:0]        func;
    logic [ROOT_W-1:0] space_root;
  } in_t;

  typedef struct packed {
    logic                ok;
    logic [OUT_ID_W-1:0] thread_id;
    logic                switched;
    logic [ROOT_W-1:0]   root_to_load;
    logic                user_thread;
  } out_t;

  // controller to datapath
  typedef struct packed {
    logic latch_in;
    logic rd_cur;
    logic kill_cur;
    logic create_fail;
    logic cr_write;
    logic cr_splice;
    logic walk_init;
    logic walk_step;
    logic walk_hit;
    logic walk_fail;
    logic sw_old;
    logic sw_new;
    logic out_load;
  } cmd_t;

  // datapath to controller
  typedef struct packed {
    logic [1:0] func;
    logic       full;
    logic       walk_more;
    logic       walk_hit;
    logic       old_run;
    logic       out_free;
  } sts_t;

endpackage

`default_nettype wire

// ----- hw/rtl/rrts_ram.sv -----
// generic single write port ram with registered read
// no dependencies
`default_nettype none

module rrts_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic                     re,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

`default_nettype wire

// ----- hw/rtl/rrts_ctrl.sv -----
// sequencer of the thread ring scheduler: one request at a time
// depends on rrts_pkg
`default_nettype none

module rrts_ctrl (
  input  wire logic          clk,
  input  wire logic          rst_n,
  input  wire logic          in_valid,
  output logic               in_stall,
  input  wire rrts_pkg::sts_t sts,
  output rrts_pkg::cmd_t      cmd
);

  typedef enum logic [3:0] {
    S_IDLE,
    S_START,
    S_CR_LINK,
    S_CR_SPLICE,
    S_WK_FIRST,
    S_WK_CHK,
    S_SW_OLD,
    S_SW_NEW,
    S_FINISH
  } state_t;

  state_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  // no request is taken while reset is held
  assign in_stall = !rst_n || (state_r != S_IDLE);

  always_comb begin
    cmd       = '0;
    state_nxt = state_r;
    case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          cmd.latch_in = 1'b1;
          state_nxt    = S_START;
        end
      end
      S_START: begin
        cmd.rd_cur   = 1'b1;
        cmd.kill_cur = (sts.func == rrts_pkg::FN_EXIT);
        if (sts.func inside {rrts_pkg::FN_CREATE_K, rrts_pkg::FN_CREATE_U}) begin
          if (sts.full) begin
            cmd.create_fail = 1'b1;
            state_nxt       = S_FINISH;
          end else begin
            state_nxt = S_CR_LINK;
          end
        end else begin
          state_nxt = S_WK_FIRST;
        end
      end
      S_CR_LINK: begin
        cmd.cr_write = 1'b1;
        state_nxt    = S_CR_SPLICE;
      end
      S_CR_SPLICE: begin
        cmd.cr_splice = 1'b1;
        state_nxt     = S_FINISH;
      end
      S_WK_FIRST: begin
        cmd.walk_init = 1'b1;
        state_nxt     = S_WK_CHK;
      end
      S_WK_CHK: begin
        if (sts.walk_more) begin
          cmd.walk_step = 1'b1;
        end else if (sts.walk_hit) begin
          cmd.walk_hit = 1'b1;
          state_nxt    = sts.old_run ? S_SW_OLD : S_SW_NEW;
        end else begin
          cmd.walk_fail = 1'b1;
          state_nxt     = S_FINISH;
        end
      end
      S_SW_OLD: begin
        cmd.sw_old = 1'b1;
        state_nxt  = S_SW_NEW;
      end
      S_SW_NEW: begin
        cmd.sw_new = 1'b1;
        state_nxt  = S_FINISH;
      end
      S_FINISH: begin
        if (sts.out_free) begin
          cmd.out_load = 1'b1;
          state_nxt    = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

endmodule

`default_nettype wire

// ----- hw/rtl/rrts_dp.sv -----
// datapath of the thread ring scheduler: thread tables, walk pointer, result
// depends on rrts_pkg and rrts_ram
`default_nettype none

module rrts_dp (
  input  wire logic                         clk,
  input  wire logic                         rst_n,
  input  wire rrts_pkg::in_t                in_data,
  input  wire logic                         cfg_we,
  input  wire logic [rrts_pkg::ROOT_W-1:0]  cfg_wdata,
  input  wire rrts_pkg::cmd_t               cmd,
  output rrts_pkg::sts_t                    sts,
  output logic                              out_valid,
  input  wire logic                         out_stall,
  output rrts_pkg::out_t                    out_data
);

  localparam int IW = rrts_pkg::ID_W;
  localparam int CW = rrts_pkg::CNT_W;
  localparam int RW = rrts_pkg::ROOT_W;

  rrts_pkg::in_t  req_r;
  rrts_pkg::out_t res_r;
  rrts_pkg::out_t out_r;
  logic           out_valid_r;

  logic [RW-1:0] kern_root_r;
  logic [IW-1:0] run_id_r;
  logic [CW-1:0] next_free_r;
  logic [IW-1:0] old_r;
  logic [IW-1:0] nxt_r;
  logic [CW-1:0] visits_r;
  logic          old_run_r;

  // slot 0 lives in flops so that its reset state needs no ram clearing
  logic [1:0]    stat0_r;
  logic [IW-1:0] link0_r;
  logic          rd_zero_r;

  logic [IW-1:0] tid;
  logic [IW-1:0] rd_addr;
  logic          rd_en;
  logic [IW-1:0] link_ram_q;
  logic [1:0]    stat_ram_q;
  logic [RW:0]   root_ram_q;
  logic [IW-1:0] link_q;
  logic [1:0]    stat_q;
  logic [RW:0]   root_q;

  logic          link_we;
  logic [IW-1:0] link_waddr;
  logic [IW-1:0] link_wdata;
  logic          stat_wr;
  logic [IW-1:0] stat_waddr;
  logic [1:0]    stat_wdata;
  logic [RW:0]   root_wdata;
  logic          nxt_is_old;
  logic          stat_skip;

  assign tid     = next_free_r[IW-1:0];
  assign rd_en   = cmd.rd_cur | cmd.walk_init | cmd.walk_step;
  assign rd_addr = cmd.rd_cur ? run_id_r : link_q;

  assign link_q = rd_zero_r ? link0_r : link_ram_q;
  assign stat_q = rd_zero_r ? stat0_r : stat_ram_q;
  assign root_q = rd_zero_r ? '0 : root_ram_q;

  always_comb begin
    link_we    = 1'b0;
    link_waddr = tid;
    link_wdata = link_q;
    if (cmd.cr_write) begin
      link_we = 1'b1;
    end else if (cmd.cr_splice) begin
      link_we    = (run_id_r != '0);
      link_waddr = run_id_r;
      link_wdata = tid;
    end
  end

  always_comb begin
    stat_wr    = 1'b1;
    stat_waddr = run_id_r;
    stat_wdata = rrts_pkg::ST_DEAD;
    if (cmd.cr_write) begin
      stat_waddr = tid;
      stat_wdata = rrts_pkg::ST_READY;
    end else if (cmd.sw_old) begin
      stat_waddr = old_r;
      stat_wdata = rrts_pkg::ST_READY;
    end else if (cmd.sw_new) begin
      stat_waddr = nxt_r;
      stat_wdata = rrts_pkg::ST_RUNNING;
    end else if (!cmd.kill_cur) begin
      stat_wr = 1'b0;
    end
  end

  assign root_wdata = (req_r.func == rrts_pkg::FN_CREATE_U) ? {1'b1, req_r.space_root} : '0;

  rrts_ram #(.WIDTH(IW), .DEPTH(rrts_pkg::THREAD_SLOTS)) u_link_ram (
    .clk   (clk),
    .we    (link_we),
    .waddr (link_waddr),
    .wdata (link_wdata),
    .re    (rd_en),
    .raddr (rd_addr),
    .rdata (link_ram_q)
  );

  rrts_ram #(.WIDTH(2), .DEPTH(rrts_pkg::THREAD_SLOTS)) u_stat_ram (
    .clk   (clk),
    .we    (stat_wr && (stat_waddr != '0)),
    .waddr (stat_waddr),
    .wdata (stat_wdata),
    .re    (rd_en),
    .raddr (rd_addr),
    .rdata (stat_ram_q)
  );

  // user flag on top of the own root
  rrts_ram #(.WIDTH(RW + 1), .DEPTH(rrts_pkg::THREAD_SLOTS)) u_root_ram (
    .clk   (clk),
    .we    (cmd.cr_write),
    .waddr (tid),
    .wdata (root_wdata),
    .re    (rd_en),
    .raddr (rd_addr),
    .rdata (root_ram_q)
  );

  assign nxt_is_old = (nxt_r == old_r);
  assign stat_skip  = stat_q inside {rrts_pkg::ST_DEAD, rrts_pkg::ST_BLOCKED};

  assign sts.func      = req_r.func;
  assign sts.full      = (next_free_r >= CW'(rrts_pkg::THREAD_SLOTS));
  assign sts.walk_more = stat_skip && !nxt_is_old && (visits_r < CW'(rrts_pkg::THREAD_SLOTS));
  assign sts.walk_hit  = !nxt_is_old && (stat_q == rrts_pkg::ST_READY);
  assign sts.old_run   = old_run_r;
  assign sts.out_free  = !out_valid_r || !out_stall;

  // control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      kern_root_r <= '0;
      run_id_r    <= '0;
      next_free_r <= CW'(1);
      stat0_r     <= rrts_pkg::ST_RUNNING;
      link0_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (cfg_we) begin
        kern_root_r <= cfg_wdata;
      end
      if (stat_wr && (stat_waddr == '0)) begin
        stat0_r <= stat_wdata;
      end
      if (cmd.cr_splice) begin
        next_free_r <= next_free_r + CW'(1);
        if (run_id_r == '0) begin
          link0_r <= tid;
        end
      end
      if (cmd.sw_new) begin
        run_id_r <= nxt_r;
      end
      if (cmd.out_load) begin
        out_valid_r <= 1'b1;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // payload and walk registers
  always_ff @(posedge clk) begin
    if (cmd.latch_in) begin
      req_r <= in_data;
    end
    if (rd_en) begin
      rd_zero_r <= (rd_addr == '0);
    end
    if (cmd.rd_cur) begin
      old_r <= run_id_r;
    end
    if (cmd.walk_init) begin
      old_run_r <= (req_r.func == rrts_pkg::FN_YIELD) && (stat_q == rrts_pkg::ST_RUNNING);
      visits_r  <= '0;
    end else if (cmd.walk_step) begin
      visits_r <= visits_r + CW'(1);
    end
    if (cmd.walk_init || cmd.walk_step) begin
      nxt_r <= link_q;
    end
    if (cmd.create_fail) begin
      res_r <= '0;
    end else if (cmd.cr_splice) begin
      res_r           <= '0;
      res_r.ok        <= 1'b1;
      res_r.thread_id <= rrts_pkg::OUT_ID_W'(tid);
    end else if (cmd.walk_fail) begin
      res_r           <= '0;
      res_r.thread_id <= rrts_pkg::OUT_ID_W'(old_r);
    end else if (cmd.walk_hit) begin
      res_r.ok           <= 1'b1;
      res_r.thread_id    <= rrts_pkg::OUT_ID_W'(nxt_r);
      res_r.switched     <= 1'b1;
      res_r.root_to_load <= (root_q[RW-1:0] != '0) ? root_q[RW-1:0] : kern_root_r;
      res_r.user_thread  <= root_q[RW];
    end
    if (cmd.out_load) begin
      out_r <= res_r;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_r;

endmodule

`default_nettype wire

// ----- hw/rtl/round_robin_thread_ring_scheduler_core.sv -----
// top level of the round-robin thread ring scheduler
// depends on rrts_pkg, rrts_ctrl, rrts_dp and the assertion macro header
//
//   channel | handshake           | payload
//   --------+---------------------+---------------------------
//   in      | in_valid / in_stall | in_data (rrts_pkg::in_t)
//   out     | out_valid/out_stall | out_data (rrts_pkg::out_t)
//   cfg     | cfg_we              | cfg_wdata (kernel space root)
//
// one request at a time: a create runs start, link, splice and finish, or start
// then finish when the table is full; a yield or exit runs start, walk first,
// a walk check per link followed (at most THREAD_SLOTS - 1 extra links, one ram
// read each), switch old on a yield whose old thread is running, switch new and
// finish, or walk then finish when no ready thread is found. a stalled result
// holds finish, in_stall stays high meanwhile. sync reset holds in_stall; slot 0 runs alone, no ram clear
`default_nettype none

`include "round_robin_thread_ring_scheduler_core_macros.svh"

module round_robin_thread_ring_scheduler_core (
  input  wire logic                        clk,
  input  wire logic                        rst_n,
  input  wire logic                        in_valid,
  output logic                             in_stall,
  input  wire rrts_pkg::in_t               in_data,
  output logic                             out_valid,
  input  wire logic                        out_stall,
  output rrts_pkg::out_t                   out_data,
  input  wire logic                        cfg_we,
  input  wire logic [rrts_pkg::ROOT_W-1:0] cfg_wdata
);

  rrts_pkg::cmd_t cmd;
  rrts_pkg::sts_t sts;
  logic [4:0]     tbl_wr;

  rrts_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .sts      (sts),
    .cmd      (cmd)
  );

  rrts_dp u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_data   (in_data),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata),
    .cmd       (cmd),
    .sts       (sts),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
  );

  assign tbl_wr = {cmd.kill_cur, cmd.cr_write, cmd.cr_splice, cmd.sw_old, cmd.sw_new};

  `RRTS_ASSERT_NEXT(a_busy_after_accept, in_valid && !in_stall, in_stall, "no stall after accept")
  `RRTS_ASSERT_NOW(a_no_overwrite, cmd.out_load, !out_valid || !out_stall, "result overwritten")
  `RRTS_ASSERT_NEXT(a_load_shows, cmd.out_load, out_valid, "loaded result not presented")
  `RRTS_ASSERT_NOW(a_one_write, 1'b1, $onehot0(tbl_wr), "table write collision")

endmodule

`default_nettype wire
